// ===== design/wfcd_pkg.sv =====
package wfcd_pkg;

    localparam int unsigned MAX_PAYLOAD = 4096;
    localparam int unsigned HDR_LEN     = 84;
    localparam int unsigned MIN_FRAME   = 88;
    localparam int unsigned CNT_W       = 13;
    localparam int unsigned TDATA_W     = 344;

    localparam logic [31:0] FNV_START = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_PREAMBLE = 4'd2,
        ST_TOO_LONG = 4'd3,
        ST_LENGTH   = 4'd4,
        ST_HDR_HASH = 4'd5,
        ST_FRM_HASH = 4'd6,
        ST_DIGEST   = 4'd7,
        ST_FIELDS   = 4'd8
    } status_t;

    typedef struct packed {
        logic    accept;       // input item taken this cycle
        logic    comp_step;    // advance the running compression
        logic    pad_step;     // absorb one padding byte
        logic    load_status;  // load status result and clear the frame
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic    block_full;   // the byte absorbed this cycle completes a block
        logic    comp_done;    // final cycle of a compression
        logic    pad_finished;
        logic    out_free;
        status_t pre_status;
        status_t check_status;
    } dp_stat_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_s1(input word_t x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t sml_s0(input word_t x);
        sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sml_s1(input word_t x);
        sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t sha_init(input logic [2:0] i);
        unique case (i)
            3'd0: sha_init = 32'h6a09e667;
            3'd1: sha_init = 32'hbb67ae85;
            3'd2: sha_init = 32'h3c6ef372;
            3'd3: sha_init = 32'ha54ff53a;
            3'd4: sha_init = 32'h510e527f;
            3'd5: sha_init = 32'h9b05688c;
            3'd6: sha_init = 32'h1f83d9ab;
            default: sha_init = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t sha_k(input logic [5:0] t);
        unique case (t)
            6'd0:  sha_k = 32'h428a2f98;  6'd1:  sha_k = 32'h71374491;
            6'd2:  sha_k = 32'hb5c0fbcf;  6'd3:  sha_k = 32'he9b5dba5;
            6'd4:  sha_k = 32'h3956c25b;  6'd5:  sha_k = 32'h59f111f1;
            6'd6:  sha_k = 32'h923f82a4;  6'd7:  sha_k = 32'hab1c5ed5;
            6'd8:  sha_k = 32'hd807aa98;  6'd9:  sha_k = 32'h12835b01;
            6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
            6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
            6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
            6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
            6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
            6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
            6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
            6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
            6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
            6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
            6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
            6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
            6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
            6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
            6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
            6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
            6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
            6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
            6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
            6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
            6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
            6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
            6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
            6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
            6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
            6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
            6'd62: sha_k = 32'hbef9a3f7;  default: sha_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== design/wire_frame_checker_deframer.sv =====
// Checks and strips one wire frame per run of input items: one frame byte per item,
// tlast on the last byte. Payload bytes leave one per item as they arrive
// (tuser 0); after the end byte one status item (tuser 1) carries the first
// failing check and the header fields. A consumer drops the payload on non-zero
// status. Every completed 64-byte payload block stops input while the single
// SHA-256 round unit compresses it. At frame end, if every check up to the frame
// hash passes, padding goes in at one byte a cycle (9 to 72 bytes), paused by one
// or two further compressions, before the status item; else S_FIN passes to S_EMIT,
// which loads it once the output register is free. payload_room is written through
// cfg_wr_en/cfg_wr_data, by the user only while the block is idle (not enforced).
module wire_frame_checker_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // frame_byte
    input  logic                          s_tlast,   // frame_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // payload_byte, status, class_bytes, session word, nonce_value, sending node,
    // virtual_time, message number, chunk number, chunk total, length word, zero fill
    output logic [wfcd_pkg::TDATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser,   // is_status
    input  logic                          cfg_wr_en,
    input  logic [12:0]                   cfg_wr_data
);
    import wfcd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    wfcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfcd_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== design/wfcd_datapath.sv =====
module wfcd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wfcd_pkg::ctrl_cmd_t           cmd,
    output wfcd_pkg::dp_stat_t            stat,
    input  logic [7:0]                    in_byte,
    input  logic                          in_end,
    input  logic                          cfg_wr_en,
    input  logic [12:0]                   cfg_wr_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wfcd_pkg::TDATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser
);
    import wfcd_pkg::*;

    logic [12:0]      room_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    status_t          ferr_reg, ferr_next;
    logic [39:0]      class_reg, class_next;
    word_t            hw_reg [0:8];
    word_t            hw_next [0:8];
    logic [255:0]     dig_reg, dig_next;
    word_t            fnv_reg, fnv_next;
    word_t            snap_reg, snap_next;
    word_t            recv_reg, recv_next;
    word_t            chain_reg [0:7];
    word_t            chain_next [0:7];
    word_t            va_reg [0:7];
    word_t            va_next [0:7];
    word_t            vin [0:7];
    word_t            w_reg [0:15];
    word_t            w_next [0:15];
    logic [5:0]       fill_reg, fill_next;
    logic [6:0]       rnd_reg, rnd_next;
    logic             mark_reg, mark_next;
    logic [3:0]       pidx_reg, pidx_next;
    logic             ovalid_reg, ovalid_next;
    logic [TDATA_W-1:0] odata_reg, odata_next;
    logic             ostat_reg, ostat_next;

    word_t        plen;
    logic         len_ok, in_payload, in_body, absorb, out_free;
    logic [32:0]  body_end, frame_len;
    logic [7:0]   abs_byte, pad_byte;
    logic [63:0]  len_bits;
    word_t        t1, t2, wnew, hw_shift;
    logic [3:0]   hk;
    word_t        fnv_prod;
    logic [255:0] digest_calc;
    logic [7:0]   f_dir, f_typ, f_d0, f_d4;
    logic         fields_bad;
    logic [7:0]   magic_b;

    assign plen       = hw_reg[8];
    assign len_ok     = plen <= 32'(MAX_PAYLOAD);
    assign body_end   = 33'(HDR_LEN) + {1'b0, plen};
    assign frame_len  = 33'(MIN_FRAME) + {1'b0, plen};
    assign in_payload = (cnt_reg >= CNT_W'(HDR_LEN)) && len_ok
                        && ({20'd0, cnt_reg} < body_end);
    assign in_body    = (cnt_reg < CNT_W'(HDR_LEN)) || in_payload;
    assign out_free   = !ovalid_reg || m_tready;
    assign len_bits   = {29'd0, plen, 3'd0};
    assign hk         = 4'((cnt_reg - CNT_W'(12)) >> 2);
    assign fnv_prod   = (fnv_reg ^ {24'd0, in_byte}) * FNV_PRIME;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: magic_b = 8'h51;
            2'd1: magic_b = 8'h56;
            2'd2: magic_b = 8'h52;
            default: magic_b = 8'h54;
        endcase
    end

    // Padding: the marker byte, zeros up to offset 56, then the bit length.
    always_comb begin
        if (!mark_reg) begin
            pad_byte = 8'h80;
        end else if (pidx_reg == 4'd0 && fill_reg != 6'd56) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = len_bits[8 * (7 - pidx_reg[2:0]) +: 8];
        end
    end

    assign absorb   = (cmd.accept && in_payload) || cmd.pad_step;
    assign abs_byte = cmd.pad_step ? pad_byte : in_byte;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            vin[i] = (rnd_reg == 7'd0) ? chain_reg[i] : va_reg[i];
        end
        t1 = vin[7] + big_s1(vin[4]) + ((vin[4] & vin[5]) ^ (~vin[4] & vin[6]))
             + sha_k(rnd_reg[5:0]) + w_reg[0];
        t2 = big_s0(vin[0]) + ((vin[0] & vin[1]) ^ (vin[0] & vin[2]) ^ (vin[1] & vin[2]));
        wnew = sml_s1(w_reg[14]) + w_reg[9] + sml_s0(w_reg[1]) + w_reg[0];
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digest_calc[255 - 32 * i -: 32] = chain_reg[i];
        end
    end

    assign f_dir = class_reg[39:32];
    assign f_typ = class_reg[31:24];
    assign f_d0  = class_reg[15:8];
    assign f_d4  = class_reg[7:0];

    always_comb begin
        fields_bad = (f_dir > 8'd1) || (f_typ < 8'd1) || (f_typ > 8'd4)
                     || (f_d0 > 8'd3) || (f_d4 > 8'd4)
                     || (hw_reg[7] == 32'd0) || (hw_reg[6] >= hw_reg[7])
                     || !len_ok;
        if (f_typ == 8'd1) begin
            fields_bad = fields_bad || (f_dir != 8'd0);
        end else begin
            fields_bad = fields_bad || (f_dir != 8'd1);
        end
    end

    always_comb begin
        priority if (cnt_reg < CNT_W'(MIN_FRAME)) begin
            stat.pre_status = ST_SHORT;
        end else if (ferr_reg == ST_PREAMBLE || ferr_reg == ST_TOO_LONG) begin
            stat.pre_status = ferr_reg;
        end else if ({20'd0, cnt_reg} != frame_len || {19'd0, room_reg} < plen) begin
            stat.pre_status = ST_LENGTH;
        end else if (ferr_reg == ST_HDR_HASH) begin
            stat.pre_status = ST_HDR_HASH;
        end else if (fnv_reg != recv_reg) begin
            stat.pre_status = ST_FRM_HASH;
        end else begin
            stat.pre_status = ST_OK;
        end
        if (digest_calc != dig_reg) begin
            stat.check_status = ST_DIGEST;
        end else if (fields_bad) begin
            stat.check_status = ST_FIELDS;
        end else begin
            stat.check_status = ST_OK;
        end
        stat.block_full   = absorb && (fill_reg == 6'd63);
        stat.comp_done    = cmd.comp_step && (rnd_reg == 7'd64);
        stat.pad_finished = (pidx_reg == 4'd8);
        stat.out_free     = out_free;
    end

    always_comb begin
        cnt_next   = cnt_reg;
        ferr_next  = ferr_reg;
        class_next = class_reg;
        dig_next   = dig_reg;
        fnv_next   = fnv_reg;
        snap_next  = snap_reg;
        recv_next  = recv_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        mark_next  = mark_reg;
        pidx_next  = pidx_reg;
        hw_shift   = {hw_reg[hk][23:0], in_byte};
        for (int i = 0; i < 9; i++) hw_next[i] = hw_reg[i];
        for (int i = 0; i < 8; i++) begin
            chain_next[i] = chain_reg[i];
            va_next[i]    = va_reg[i];
        end
        for (int i = 0; i < 16; i++) w_next[i] = w_reg[i];

        if (cmd.accept) begin
            if (cnt_reg != {CNT_W{1'b1}}) cnt_next = cnt_reg + CNT_W'(1);
            if (in_body) fnv_next = fnv_prod[31:0];
            priority if (cnt_reg < CNT_W'(4)) begin
                if (in_byte != magic_b && ferr_reg == ST_OK) ferr_next = ST_PREAMBLE;
            end else if (cnt_reg == CNT_W'(4)) begin
                if (in_byte != 8'd1 && ferr_reg == ST_OK) ferr_next = ST_PREAMBLE;
            end else if (cnt_reg < CNT_W'(10)) begin
                class_next = {class_reg[31:0], in_byte};
            end else if (cnt_reg == CNT_W'(10)) begin
                if (in_byte != 8'd0 && ferr_reg == ST_OK) ferr_next = ST_PREAMBLE;
            end else if (cnt_reg == CNT_W'(11)) begin
                if (in_byte != 8'(HDR_LEN) && ferr_reg == ST_OK) ferr_next = ST_PREAMBLE;
            end else if (cnt_reg < CNT_W'(48)) begin
                hw_next[hk] = hw_shift;
                if (cnt_reg == CNT_W'(47) && hw_shift > 32'(MAX_PAYLOAD)
                    && ferr_reg == ST_OK) ferr_next = ST_TOO_LONG;
            end else if (cnt_reg < CNT_W'(80)) begin
                dig_next = {dig_reg[247:0], in_byte};
                // The snapshot covers the last digest byte as well.
                if (cnt_reg == CNT_W'(79)) snap_next = fnv_prod[31:0];
            end else if (cnt_reg < CNT_W'(HDR_LEN)) begin
                recv_next = {recv_reg[23:0], in_byte};
                if (cnt_reg == CNT_W'(83) && {recv_reg[23:0], in_byte} != snap_reg
                    && ferr_reg == ST_OK) ferr_next = ST_HDR_HASH;
            end else if (!in_payload) begin
                recv_next = {recv_reg[23:0], in_byte};
            end
        end

        if (absorb) begin
            for (int i = 0; i < 15; i++) w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_next[15] = {w_reg[15][23:0], abs_byte};
            fill_next  = fill_reg + 6'd1;
        end

        if (cmd.pad_step) begin
            if (!mark_reg) begin
                mark_next = 1'b1;
            end else if (!(pidx_reg == 4'd0 && fill_reg != 6'd56)) begin
                pidx_next = pidx_reg + 4'd1;
            end
        end

        if (cmd.comp_step) begin
            if (rnd_reg == 7'd64) begin
                for (int i = 0; i < 8; i++) chain_next[i] = chain_reg[i] + va_reg[i];
                rnd_next = 7'd0;
            end else begin
                va_next[0] = t1 + t2;
                va_next[1] = vin[0];
                va_next[2] = vin[1];
                va_next[3] = vin[2];
                va_next[4] = vin[3] + t1;
                va_next[5] = vin[4];
                va_next[6] = vin[5];
                va_next[7] = vin[6];
                for (int i = 0; i < 15; i++) w_next[i] = w_reg[i + 1];
                w_next[15] = wnew;
                rnd_next   = rnd_reg + 7'd1;
            end
        end

        if (cmd.load_status) begin
            cnt_next   = '0;
            ferr_next  = ST_OK;
            class_next = '0;
            fnv_next   = FNV_START;
            snap_next  = '0;
            recv_next  = '0;
            fill_next  = '0;
            rnd_next   = '0;
            mark_next  = 1'b0;
            pidx_next  = '0;
            for (int i = 0; i < 9; i++) hw_next[i] = '0;
            for (int i = 0; i < 8; i++) chain_next[i] = sha_init(3'(i));
        end
    end

    // Output register: a payload item or the status item.
    always_comb begin
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ostat_next  = ostat_reg;
        if (cmd.accept && in_payload && !in_end) begin
            ovalid_next       = 1'b1;
            ostat_next        = 1'b0;
            odata_next        = '0;
            odata_next[7:0]   = in_byte;
        end else if (cmd.load_status) begin
            ovalid_next         = 1'b1;
            ostat_next          = 1'b1;
            odata_next          = '0;
            odata_next[11:8]    = cmd.code;
            odata_next[51:12]   = class_reg;
            odata_next[83:52]   = hw_reg[0];
            odata_next[115:84]  = hw_reg[1];
            odata_next[147:116] = hw_reg[2];
            odata_next[211:148] = {hw_reg[3], hw_reg[4]};
            odata_next[243:212] = hw_reg[5];
            odata_next[275:244] = hw_reg[6];
            odata_next[307:276] = hw_reg[7];
            odata_next[339:308] = hw_reg[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_reg   <= 13'd4096;
            cnt_reg    <= '0;
            ferr_reg   <= ST_OK;
            class_reg  <= '0;
            fnv_reg    <= FNV_START;
            snap_reg   <= '0;
            recv_reg   <= '0;
            fill_reg   <= '0;
            rnd_reg    <= '0;
            mark_reg   <= 1'b0;
            pidx_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) hw_reg[i] <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha_init(3'(i));
        end else begin
            if (cfg_wr_en) room_reg <= cfg_wr_data;
            cnt_reg    <= cnt_next;
            ferr_reg   <= ferr_next;
            class_reg  <= class_next;
            fnv_reg    <= fnv_next;
            snap_reg   <= snap_next;
            recv_reg   <= recv_next;
            fill_reg   <= fill_next;
            rnd_reg    <= rnd_next;
            mark_reg   <= mark_next;
            pidx_reg   <= pidx_next;
            ovalid_reg <= ovalid_next;
            for (int i = 0; i < 9; i++) hw_reg[i] <= hw_next[i];
            for (int i = 0; i < 8; i++) chain_reg[i] <= chain_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg   <= dig_next;
        odata_reg <= odata_next;
        ostat_reg <= ostat_next;
        for (int i = 0; i < 8; i++) va_reg[i] <= va_next[i];
        for (int i = 0; i < 16; i++) w_reg[i] <= w_next[i];
    end

    assign m_tvalid   = ovalid_reg;
    assign m_tdata    = odata_reg;
    assign m_tuser[0] = ostat_reg;

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_reg <= 7'd64)
        else $error("compression round counter out of range");

    a_no_absorb_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.comp_step && absorb))
        else $error("byte absorbed during compression");

    a_clear_after_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status |=> (cnt_reg == '0 && fill_reg == 6'd0 && ostat_reg))
        else $error("frame state not cleared after status item");

endmodule

// ===== design/wfcd_ctrl.sv =====
module wfcd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    input  wfcd_pkg::dp_stat_t   stat,
    output wfcd_pkg::ctrl_cmd_t  cmd
);
    import wfcd_pkg::*;

    typedef enum logic [5:0] {
        S_RUN   = 6'b000001,
        S_COMP  = 6'b000010,
        S_FIN   = 6'b000100,
        S_PAD   = 6'b001000,
        S_CHECK = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    logic    endp_reg, endp_next;
    logic    padm_reg, padm_next;
    status_t code_reg, code_next;
    logic    acc;

    assign s_tready = (state_reg == S_RUN) && stat.out_free;
    assign acc      = s_tready && s_tvalid;

    always_comb begin
        state_next       = state_reg;
        endp_next        = endp_reg;
        padm_next        = padm_reg;
        code_next        = code_reg;
        cmd.accept       = acc;
        cmd.comp_step    = 1'b0;
        cmd.pad_step     = 1'b0;
        cmd.load_status  = 1'b0;
        cmd.code         = code_reg;
        unique case (state_reg)
            S_RUN: begin
                if (acc) begin
                    endp_next = s_tlast;
                    if (stat.block_full) begin
                        state_next = S_COMP;
                    end else if (s_tlast) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_COMP: begin
                cmd.comp_step = 1'b1;
                if (stat.comp_done) begin
                    if (padm_reg) begin
                        state_next = stat.pad_finished ? S_CHECK : S_PAD;
                    end else begin
                        state_next = endp_reg ? S_FIN : S_RUN;
                    end
                end
            end
            S_FIN: begin
                if (stat.pre_status != ST_OK) begin
                    code_next  = stat.pre_status;
                    state_next = S_EMIT;
                end else begin
                    padm_next  = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_PAD: begin
                cmd.pad_step = 1'b1;
                if (stat.block_full) state_next = S_COMP;
            end
            S_CHECK: begin
                code_next  = stat.check_status;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_status = 1'b1;
                    endp_next       = 1'b0;
                    padm_next       = 1'b0;
                    state_next      = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
            endp_reg  <= 1'b0;
            padm_reg  <= 1'b0;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            endp_reg  <= endp_next;
            padm_reg  <= padm_next;
            code_reg  <= code_next;
        end
    end

    a_pad_only_when_checking: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAD) |-> padm_reg)
        else $error("padding outside final hash");

    a_emit_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status |-> (code_reg <= ST_FIELDS))
        else $error("status code out of range");

    a_pad_follows_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(padm_reg) |-> $past(state_reg == S_FIN))
        else $error("padding started without end of frame");

endmodule

// ===== test/wire_frame_checker_deframer_test.sv =====
`timescale 1ns / 1ps

module wire_frame_checker_deframer_test;
    import wfcd_pkg::*;

    typedef logic [7:0] octet_q[$];

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_MULT  = 32'd16777619;
    localparam logic [31:0] FRAME_MAGIC = 32'h51565254;
    localparam int unsigned COUNT_TOP  = 8191;
    localparam int unsigned IDLE_WAIT  = 300;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned ITEM_TARGET = 1850;

    localparam logic [31:0] RK[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] RH0[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Result fields from the lowest bit of tdata up.
    localparam int FIELD_LSB[11] = '{0, 8, 12, 52, 84, 116, 148, 212, 244, 276, 308};
    localparam int FIELD_W[11]   = '{8, 4, 40, 32, 32, 32, 64, 32, 32, 32, 32};

    function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha256_of(octet_q m);
        octet_q p;
        logic [31:0] h[8], w[64], v[8], t1, t2;
        logic [63:0] bits;
        logic [255:0] r;
        p = m;
        bits = 64'(m.size()) * 8;
        p.push_back(8'h80);
        while (p.size() % 64 != 56) p.push_back(8'h00);
        for (int i = 0; i < 8; i++) p.push_back(bits[63 - 8 * i -: 8]);
        h = RH0;
        for (int b = 0; b < p.size(); b += 64) begin
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    w[t] = {p[b + 4 * t], p[b + 4 * t + 1], p[b + 4 * t + 2], p[b + 4 * t + 3]};
                end else begin
                    w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                         + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
                end
            end
            v = h;
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] += v[i];
        end
        for (int i = 0; i < 8; i++) r[255 - 32 * i -: 32] = h[i];
        return r;
    endfunction

    function automatic logic [31:0] fnv_of(octet_q q);
        logic [31:0] h;
        h = HASH_BASIS;
        foreach (q[i]) h = (h ^ 32'(q[i])) * HASH_MULT;
        return h;
    endfunction

    typedef struct {
        bit                 is_status;
        logic [TDATA_W-1:0] data;
    } deframe_item_t;

    class frame_scoreboard;
        int unsigned        room;
        int unsigned        fails;
        int unsigned        bytes_taken;
        deframe_item_t      pending_q[$];
        int unsigned        count;
        status_t            first_err;
        logic [39:0]        class_reg;
        logic [31:0]        hw[9];
        logic [7:0]         digest[32];
        logic [31:0]        run_hash;
        logic [31:0]        hdr_snap;
        logic [31:0]        rx_word;
        octet_q             payload;

        function new();
            room = MAX_PAYLOAD;
            fails = 0;
            bytes_taken = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count = 0;
            first_err = ST_OK;
            class_reg = '0;
            foreach (hw[i]) hw[i] = '0;
            foreach (digest[i]) digest[i] = '0;
            run_hash = HASH_BASIS;
            hdr_snap = '0;
            rx_word = '0;
            payload.delete();
        endfunction

        function int unsigned waiting();
            return pending_q.size();
        endfunction

        function void flag(status_t code);
            if (first_err == ST_OK) first_err = code;
        endfunction

        function bit fields_valid();
            logic [7:0] dir, typ, d0, d4;
            dir = class_reg[39:32];
            typ = class_reg[31:24];
            d0 = class_reg[15:8];
            d4 = class_reg[7:0];
            if (dir > 1 || typ < 1 || typ > 4 || d0 > 3 || d4 > 4) return 0;
            if (hw[7] == 0 || hw[6] >= hw[7]) return 0;
            if (hw[8] > MAX_PAYLOAD) return 0;
            return (typ == 1) ? (dir == 0) : (dir == 1);
        endfunction

        // Accepted frame byte: advance the frame state and queue what it produces.
        function void note_byte(logic [7:0] b, bit last);
            int unsigned pos;
            logic [63:0] body_end;
            bit in_payload, in_body;
            deframe_item_t e;
            status_t st;
            logic [255:0] dg;
            bit dg_ok;
            pos = count;
            bytes_taken++;
            body_end = 64'(HDR_LEN) + 64'(hw[8]);
            in_payload = pos >= HDR_LEN && hw[8] <= MAX_PAYLOAD && 64'(pos) < body_end;
            in_body = pos < HDR_LEN || in_payload;
            if (count < COUNT_TOP) count++;
            if (in_body) run_hash = (run_hash ^ 32'(b)) * HASH_MULT;
            if (pos < 4) begin
                if (b != FRAME_MAGIC[31 - 8 * pos -: 8]) flag(ST_PREAMBLE);
            end else if (pos == 4) begin
                if (b != 8'd1) flag(ST_PREAMBLE);
            end else if (pos < 10) begin
                class_reg = {class_reg[31:0], b};
            end else if (pos == 10) begin
                if (b != 8'd0) flag(ST_PREAMBLE);
            end else if (pos == 11) begin
                if (b != 8'(HDR_LEN)) flag(ST_PREAMBLE);
            end else if (pos < 48) begin
                hw[(pos - 12) / 4] = {hw[(pos - 12) / 4][23:0], b};
                if (pos == 47 && hw[8] > MAX_PAYLOAD) flag(ST_TOO_LONG);
            end else if (pos < 80) begin
                digest[pos - 48] = b;
                if (pos == 79) hdr_snap = run_hash;
            end else if (pos < HDR_LEN) begin
                rx_word = {rx_word[23:0], b};
                if (pos == 83 && rx_word != hdr_snap) flag(ST_HDR_HASH);
            end else if (in_payload) begin
                payload.push_back(b);
            end else begin
                rx_word = {rx_word[23:0], b};
            end

            e.data = '0;
            if (!last) begin
                if (in_payload) begin
                    e.is_status = 0;
                    e.data[7:0] = b;
                    pending_q.push_back(e);
                end
                return;
            end

            if (count < MIN_FRAME) begin
                st = ST_SHORT;
            end else if (first_err == ST_PREAMBLE || first_err == ST_TOO_LONG) begin
                st = first_err;
            end else if (64'(count) != 64'(MIN_FRAME) + 64'(hw[8]) || room < hw[8]) begin
                st = ST_LENGTH;
            end else if (first_err == ST_HDR_HASH) begin
                st = ST_HDR_HASH;
            end else if (run_hash != rx_word) begin
                st = ST_FRM_HASH;
            end else begin
                dg = sha256_of(payload);
                dg_ok = 1;
                for (int i = 0; i < 32; i++) if (dg[255 - 8 * i -: 8] != digest[i]) dg_ok = 0;
                if (!dg_ok) st = ST_DIGEST;
                else if (!fields_valid()) st = ST_FIELDS;
                else st = ST_OK;
            end
            e.is_status = 1;
            e.data[11:8] = st;
            e.data[51:12] = class_reg;
            for (int i = 0; i < 3; i++) e.data[52 + 32 * i +: 32] = hw[i];
            e.data[211:148] = {hw[3], hw[4]};
            for (int i = 0; i < 4; i++) e.data[212 + 32 * i +: 32] = hw[5 + i];
            pending_q.push_back(e);
            clear_frame();
        endfunction

        function void check_item(bit is_status, logic [TDATA_W-1:0] data);
            deframe_item_t e;
            logic [63:0] xv, av, mask;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected item, is_status %0d data %h", $time, is_status, data);
                fails++;
                return;
            end
            e = pending_q.pop_front();
            if (e.is_status != is_status) begin
                $display("%0t: is_status expected %0d actual %0d", $time, e.is_status, is_status);
                fails++;
            end
            for (int i = 0; i < 11; i++) begin
                mask = (FIELD_W[i] == 64) ? '1 : ((64'd1 << FIELD_W[i]) - 1);
                xv = 64'(e.data >> FIELD_LSB[i]) & mask;
                av = 64'(data >> FIELD_LSB[i]) & mask;
                if (xv !== av) begin
                    $display("%0t: field at bit %0d expected %h actual %h",
                             $time, FIELD_LSB[i], xv, av);
                    fails++;
                end
            end
            if (data[TDATA_W-1:340] !== '0) begin
                $display("%0t: fill bits expected 0 actual %h", $time, data[TDATA_W-1:340]);
                fails++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en;
    logic [12:0]          cfg_wr_data;

    frame_scoreboard sb;
    bit calm;
    int unsigned quiet_cycles;

    wire_frame_checker_deframer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Alternates periods of random gaps with periods of full throughput.
    initial begin
        calm = 0;
        forever begin
            repeat ($urandom_range(100, 400)) @(negedge aclk);
            calm = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready = 0;
            repeat (calm ? 0 : $urandom_range(0, 10)) @(negedge aclk);
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_item(m_tuser[0], m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("wire_frame_checker_deframer: mismatch");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        s_tvalid = 0;
        repeat (calm ? 0 : $urandom_range(0, 10)) @(negedge aclk);
        s_tvalid = 1;
        s_tdata = b;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic send_frame(octet_q f);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic settle();
        while (sb.waiting() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic set_room(logic [12:0] v);
        settle();
        cfg_wr_en = 1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 0;
        sb.room = v;
    endtask

    // Builds a frame of n random payload bytes and length word plen_w; wild draws the class
    // bytes and chunk words near their limits so that the field rules fail often.
    function automatic octet_q build_frame(int unsigned n, logic [31:0] plen_w, bit wild,
                                           bit bad_digest);
        octet_q f, pay;
        logic [31:0] w[9];
        logic [7:0] cls[5];
        logic [255:0] dg;
        logic [31:0] h;
        cls[1] = 8'($urandom_range(1, 4));
        cls[0] = (cls[1] == 1) ? 8'd0 : 8'd1;
        cls[2] = 8'($urandom);
        cls[3] = 8'($urandom_range(0, 3));
        cls[4] = 8'($urandom_range(0, 4));
        for (int i = 0; i < 6; i++) w[i] = $urandom;
        w[7] = $urandom_range(1, 200);
        w[6] = $urandom_range(0, w[7] - 1);
        if ($urandom_range(0, 7) == 0) begin
            w[7] = 32'hFFFF_FFFF;
            w[6] = 32'hFFFF_FFFE;
        end
        if (wild) begin
            foreach (cls[i]) if (i != 2) cls[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                                               : 8'($urandom_range(0, 5));
            w[7] = $urandom_range(0, 3);
            w[6] = $urandom_range(0, 3);
        end
        w[8] = plen_w;
        for (int i = 0; i < 4; i++) f.push_back(FRAME_MAGIC[31 - 8 * i -: 8]);
        f.push_back(8'd1);
        foreach (cls[i]) f.push_back(cls[i]);
        f.push_back(8'd0);
        f.push_back(8'(HDR_LEN));
        foreach (w[i]) for (int j = 0; j < 4; j++) f.push_back(w[i][31 - 8 * j -: 8]);
        repeat (n) pay.push_back(8'($urandom));
        dg = sha256_of(pay);
        if (bad_digest) dg[8 * $urandom_range(0, 31) +: 8] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < 32; i++) f.push_back(dg[255 - 8 * i -: 8]);
        h = fnv_of(f);
        for (int i = 0; i < 4; i++) f.push_back(h[31 - 8 * i -: 8]);
        foreach (pay[i]) f.push_back(pay[i]);
        h = fnv_of(f);
        for (int i = 0; i < 4; i++) f.push_back(h[31 - 8 * i -: 8]);
        return f;
    endfunction

    function automatic octet_q good_frame(int unsigned n);
        return build_frame(n, n, 0, 0);
    endfunction

    function automatic octet_q flipped(octet_q f, int unsigned pos);
        f[pos] ^= 8'($urandom_range(1, 255));
        return f;
    endfunction

    initial begin
        octet_q f;
        int unsigned n, kind;
        sb = new();
        quiet_cycles = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed frames: block boundaries of the hash padding, each failing check.
        send_frame(good_frame(0));
        send_frame(good_frame(1));
        send_frame(good_frame(55));
        send_frame(good_frame(56));
        send_frame(good_frame(64));
        f = good_frame(3);
        f[f.size() - 1] = 8'hFF;
        send_frame(f);
        send_frame('{8'h00});
        f = good_frame(0);
        f = f[0:86];
        send_frame(f);
        send_frame(flipped(good_frame(2), 0));
        send_frame(flipped(good_frame(2), 4));
        send_frame(flipped(good_frame(2), 10));
        send_frame(flipped(good_frame(2), 11));
        send_frame(flipped(good_frame(2), 82));
        send_frame(flipped(good_frame(2), 90));
        send_frame(build_frame(4, 4, 0, 1));
        send_frame(build_frame(4, 4, 1, 0));
        send_frame(build_frame(3, 32'hFFFF_FFFF, 0, 0));
        send_frame(build_frame(2, MAX_PAYLOAD + 1, 0, 0));
        f = good_frame(2);
        f.push_back(8'hA5);
        send_frame(f);
        f = good_frame(20);
        f = f[0:94];
        send_frame(f);
        set_room(13'd0);
        send_frame(good_frame(0));
        send_frame(good_frame(5));
        set_room(13'h1FFF);
        send_frame(good_frame(1));
        set_room(13'(MAX_PAYLOAD));

        while (sb.bytes_taken < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                set_room(($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 200))
                                                     : 13'(MAX_PAYLOAD));
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 70);
            kind = $urandom_range(0, 15);
            case (kind)
                0: begin
                    f = good_frame(n);
                    f = f[0:$urandom_range(0, f.size() - 2)];
                end
                1: f = flipped(good_frame(n), $urandom_range(0, 87 + n));
                2: begin
                    f = good_frame(n);
                    repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
                end
                3: f = build_frame(n, n, 1, 0);
                4: f = build_frame(n, n, 0, 1);
                5: f = build_frame(n, $urandom_range(MAX_PAYLOAD + 1, 32'hFFFF_FFFF), 0, 0);
                6: begin
                    f.delete();
                    repeat ($urandom_range(1, 120)) f.push_back(8'($urandom));
                end
                default: f = good_frame(n);
            endcase
            send_frame(f);
        end

        settle();
        if (sb.fails == 0) begin
            $display("wire_frame_checker_deframer: match");
        end else begin
            $display("wire_frame_checker_deframer: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/wfcd_pkg.sv
design/wfcd_datapath.sv
design/wfcd_ctrl.sv
design/wire_frame_checker_deframer.sv
test/wire_frame_checker_deframer_test.sv
